// ===== src/random_order_bag_unit_assert.svh =====
// Assertion macros for the random order bag unit.
`ifndef RANDOM_ORDER_BAG_UNIT_ASSERT_SVH
`define RANDOM_ORDER_BAG_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Checks that a condition holds at every clock edge outside reset.
`define ROB_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);
// Checks that a trigger is followed by a condition in the next cycle.
`define ROB_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error(msg);
`else
`define ROB_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ROB_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg)
`endif
`endif

// ===== src/rob_pkg.sv =====
// Package with the sizes, operation codes and status codes of the random order bag.
`default_nettype none
package rob_pkg;

	localparam int CAPACITY   = 1024;
	localparam int DATA_WIDTH = 32;
	localparam int RND_W      = 31;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int BIT_CNT_W  = $clog2(RND_W);

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_BEGIN = 2'd1,
		OP_NEXT  = 2'd2,
		OP_PREV  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_EDGE = 2'd2
	} status_t;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_DIV  = 8'b0000_0010,
		S_RDJ  = 8'b0000_0100,
		S_WRN  = 8'b0000_1000,
		S_WRJ  = 8'b0001_0000,
		S_RDP  = 8'b0010_0000,
		S_RDK  = 8'b0100_0000,
		S_RES  = 8'b1000_0000
	} state_t;

endpackage
`default_nettype wire

// ===== src/random_order_bag_unit.sv =====
// Top level of the random order bag: item store, order store and shuffle sequencer.
// The bag holds up to 1024 items of 32 bits and hands them back in a random order.
// An add item (op 0) stores the item at the next free slot and runs one inside-out
// Fisher-Yates step against the order store, with the swap partner chosen as
// random_word modulo the new count; the order is therefore fixed when items are
// added, every begin (op 1) replays the same order, and an add cancels any walk in
// progress. Next (op 2) and previous (op 3) move the walk position and report a
// boundary when they cannot move; an add to a full bag reports full and changes
// nothing. Every accepted item yields exactly one result with the status, the item
// at the walk position (zero at the end), an end flag and the current count. The
// block works on one item at a time. A successful add runs the bit-serial modulo
// (one quotient bit per cycle over the 31-bit random word), followed by one read
// and two writes through the single write port of the order store. Begin, next,
// previous and a rejected add run the chained reads of the order store and the
// item store, and skip the item store read when the walk stands at its end. A new
// item is taken in the cycle after the previous result is registered, even while
// that result still waits on a stalled consumer. Both stores need no clearing
// after reset, so the block is ready at once.
`default_nettype none
`include "random_order_bag_unit_assert.svh"

module random_order_bag_unit
	import rob_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire logic [1:0]            op,
	input  wire logic [DATA_WIDTH-1:0] item,
	input  wire logic [RND_W-1:0]      random_word,

	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	output logic [1:0]                 status,
	output logic [DATA_WIDTH-1:0]      current_item,
	output logic                       at_end,
	output logic [CNT_W-1:0]           item_count
);

	// Storage. Both memories have one write port and one registered read port.
	logic [DATA_WIDTH-1:0] item_mem [CAPACITY];
	logic [IDX_W-1:0]      order_mem [CAPACITY];

	logic                  item_we;
	logic [IDX_W-1:0]      item_waddr;
	logic [IDX_W-1:0]      item_raddr;
	logic [DATA_WIDTH-1:0] item_rdata;

	logic                  order_we;
	logic [IDX_W-1:0]      order_waddr;
	logic [IDX_W-1:0]      order_wdata;
	logic [IDX_W-1:0]      order_raddr;
	logic [IDX_W-1:0]      order_rdata;

	// Control state.
	state_t                state_q;
	logic [CNT_W-1:0]      held_count_q;
	logic [CNT_W-1:0]      walk_pos_q;
	logic [CNT_W-1:0]      walk_end_q;
	status_t               status_q;
	logic [DATA_WIDTH-1:0] cur_q;
	logic                  rsp_valid_q;

	// Shuffle working registers: slot of the new item and the modulo unit.
	logic [IDX_W-1:0]      n_q;
	logic [CNT_W-1:0]      div_q;
	logic [CNT_W-1:0]      rem_q;
	logic [RND_W-1:0]      rnd_q;
	logic [BIT_CNT_W-1:0]  bit_cnt_q;

	logic                  req_accept;
	logic                  bag_full;
	logic                  add_ok;
	logic [CNT_W:0]        trial;
	logic                  trial_ge;
	logic                  rsp_free;

	assign req_stall  = (state_q != S_IDLE);
	assign req_accept = req_valid && !req_stall;
	assign bag_full   = (held_count_q == CNT_W'(CAPACITY));
	assign add_ok     = req_accept && (op_t'(op) == OP_ADD) && !bag_full;
	assign rsp_free   = !rsp_valid_q || !rsp_stall;

	// One restoring step of the modulo: shift in the next random bit and subtract
	// the divisor when the partial remainder reaches it. The remainder always
	// stays below the divisor, so it fits the count width.
	assign trial    = {rem_q, rnd_q[RND_W-1]};
	assign trial_ge = (trial >= {1'b0, div_q});

	// The new item goes into its slot right at acceptance.
	assign item_we    = add_ok;
	assign item_waddr = held_count_q[IDX_W-1:0];
	assign item_raddr = order_rdata;

	// Order store port use: the shuffle reads the partner entry, then writes the
	// partner's old value into the new slot and the new index into the partner.
	// When the partner is the new slot itself, the second write overrides the
	// first with the new index, which is what the shuffle asks for.
	assign order_raddr = (state_q == S_RDJ) ? rem_q[IDX_W-1:0] : walk_pos_q[IDX_W-1:0];
	assign order_we    = (state_q == S_WRN) || (state_q == S_WRJ);
	assign order_waddr = (state_q == S_WRN) ? n_q : rem_q[IDX_W-1:0];
	assign order_wdata = (state_q == S_WRN) ? order_rdata : n_q;

	always_ff @(posedge clk) begin
		if (item_we) begin
			item_mem[item_waddr] <= item;
		end
		item_rdata <= item_mem[item_raddr];
	end

	always_ff @(posedge clk) begin
		if (order_we) begin
			order_mem[order_waddr] <= order_wdata;
		end
		order_rdata <= order_mem[order_raddr];
	end

	// Sequencer and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			held_count_q <= '0;
			walk_pos_q   <= '0;
			walk_end_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_accept) begin
						case (op_t'(op))
							OP_ADD: begin
								if (bag_full) begin
									state_q <= S_RDP;
								end else begin
									held_count_q <= held_count_q + CNT_W'(1);
									walk_pos_q   <= '0;
									walk_end_q   <= '0;
									state_q      <= S_DIV;
								end
							end
							OP_BEGIN: begin
								walk_pos_q <= '0;
								walk_end_q <= held_count_q;
								state_q    <= S_RDP;
							end
							OP_NEXT: begin
								if (walk_pos_q != walk_end_q) begin
									walk_pos_q <= walk_pos_q + CNT_W'(1);
								end
								state_q <= S_RDP;
							end
							default: begin
								if (walk_pos_q != '0) begin
									walk_pos_q <= walk_pos_q - CNT_W'(1);
								end
								state_q <= S_RDP;
							end
						endcase
					end
				end
				S_DIV: begin
					if (bit_cnt_q == '0) begin
						state_q <= S_RDJ;
					end
				end
				S_RDJ: begin
					state_q <= S_WRN;
				end
				S_WRN: begin
					state_q <= S_WRJ;
				end
				S_WRJ: begin
					state_q <= S_RES;
				end
				S_RDP: begin
					// Past the end there is nothing to read.
					if (walk_pos_q < walk_end_q) begin
						state_q <= S_RDK;
					end else begin
						state_q <= S_RES;
					end
				end
				S_RDK: begin
					state_q <= S_RES;
				end
				S_RES: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result valid rises when a result is registered and falls once it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == S_RES) && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Datapath registers of the current item, the modulo unit and the result.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_accept) begin
					n_q       <= held_count_q[IDX_W-1:0];
					div_q     <= held_count_q + CNT_W'(1);
					rem_q     <= '0;
					rnd_q     <= random_word;
					bit_cnt_q <= BIT_CNT_W'(RND_W - 1);
					cur_q     <= '0;
					case (op_t'(op))
						OP_ADD: begin
							status_q <= bag_full ? ST_FULL : ST_OK;
						end
						OP_NEXT: begin
							status_q <= (walk_pos_q == walk_end_q) ? ST_EDGE : ST_OK;
						end
						OP_PREV: begin
							status_q <= (walk_pos_q == '0) ? ST_EDGE : ST_OK;
						end
						default: begin
							status_q <= ST_OK;
						end
					endcase
				end
			end
			S_DIV: begin
				rnd_q     <= {rnd_q[RND_W-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
				if (trial_ge) begin
					rem_q <= CNT_W'(trial - {1'b0, div_q});
				end else begin
					rem_q <= trial[CNT_W-1:0];
				end
			end
			S_RDK: begin
				// Item data is registered at the end of this state and is picked up in the result state.
				cur_q <= '0;
			end
			default: begin
			end
		endcase
	end

	// Output register. The item read started in the previous state is valid now.
	logic               cur_from_mem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_from_mem_q <= 1'b0;
		end else if (state_q == S_RDK) begin
			cur_from_mem_q <= 1'b1;
		end else if (state_q == S_IDLE) begin
			cur_from_mem_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_RES) && rsp_free) begin
			status       <= 2'(status_q);
			current_item <= cur_from_mem_q ? item_rdata : cur_q;
			at_end       <= (walk_pos_q == walk_end_q);
			item_count   <= held_count_q;
		end
	end

	assign rsp_valid = rsp_valid_q;

	`ROB_ASSERT_ALWAYS(a_walk_in_range, clk, arst_n, walk_pos_q <= walk_end_q, "walk position passed walk end")
	`ROB_ASSERT_ALWAYS(a_end_in_count, clk, arst_n, walk_end_q <= held_count_q, "walk end exceeds item count")
	`ROB_ASSERT_ALWAYS(a_count_in_cap, clk, arst_n, held_count_q <= CNT_W'(CAPACITY), "item count exceeds capacity")
	`ROB_ASSERT_NEXT(a_add_counts, clk, arst_n, add_ok, (held_count_q == $past(held_count_q) + CNT_W'(1)) && (state_q == S_DIV), "add did not bump count")

endmodule
`default_nettype wire
